// ===== rtl/wccr_pkg.sv =====
package wccr_pkg;

   // Build limits
   localparam int MAX_CHANNEL  = 14;
   localparam int MAX_NETWORKS = 32;
   localparam int CNT_W        = $clog2(MAX_NETWORKS + 1);
   localparam int NUM_CAND     = 3;

   localparam logic [15:0] SCORE_MAX = 16'hFFFF;
   localparam logic [1:0]  LAST_ROW  = 2'd2;

   // Register map, indexed by paddr[4:2]
   localparam logic [2:0] REG_CAND_A   = 3'd0;
   localparam logic [2:0] REG_CAND_B   = 3'd1;
   localparam logic [2:0] REG_CAND_C   = 3'd2;
   localparam logic [2:0] REG_TOL      = 3'd3;
   localparam logic [2:0] REG_HI_MARGIN = 3'd4;

   localparam logic [3:0]  RST_CAND_A    = 4'd1;
   localparam logic [3:0]  RST_CAND_B    = 4'd6;
   localparam logic [3:0]  RST_CAND_C    = 4'd11;
   localparam logic [15:0] RST_TOL       = 16'd20;
   localparam logic [15:0] RST_HI_MARGIN = 16'd40;

   // Congestion levels
   localparam logic [1:0] LEVEL_EXCELLENT = 2'd0;
   localparam logic [1:0] LEVEL_GOOD      = 2'd1;
   localparam logic [1:0] LEVEL_FAIR      = 2'd2;
   localparam logic [1:0] LEVEL_POOR      = 2'd3;

   // Confidence codes
   localparam logic [1:0] CONF_UNKNOWN = 2'd0;
   localparam logic [1:0] CONF_LOW     = 2'd1;
   localparam logic [1:0] CONF_MEDIUM  = 2'd2;
   localparam logic [1:0] CONF_HIGH    = 2'd3;

   // Rounded term (impact * overlap + 50) / 100.
   // Rows: impact 100, 85, 65, 40, 20, 8. Columns: overlap 100, 80, 55, 30, 10, 0.
   localparam logic [6:0] TERM_TABLE [0:5][0:5] = '{
      '{7'd100, 7'd80, 7'd55, 7'd30, 7'd10, 7'd0},
      '{7'd85,  7'd68, 7'd47, 7'd26, 7'd9,  7'd0},
      '{7'd65,  7'd52, 7'd36, 7'd20, 7'd7,  7'd0},
      '{7'd40,  7'd32, 7'd22, 7'd12, 7'd4,  7'd0},
      '{7'd20,  7'd16, 7'd11, 7'd6,  7'd2,  7'd0},
      '{7'd8,   7'd6,  7'd4,  7'd2,  7'd1,  7'd0}
   };

   typedef logic [NUM_CAND-1:0][3:0] cand_vec_type;

   // Accumulator state as seen by the emitter
   typedef struct packed {
      logic [NUM_CAND-1:0][15:0] score;
      logic [CNT_W-1:0]          count;
      logic                      counted;
   } score_bank_type;

   // Row of the impact table for a signal strength
   function automatic logic [2:0] impact_idx(input logic signed [7:0] rssi);
      logic [2:0] idx;
      if (rssi >= -8'sd50)      idx = 3'd0;
      else if (rssi >= -8'sd60) idx = 3'd1;
      else if (rssi >= -8'sd70) idx = 3'd2;
      else if (rssi >= -8'sd80) idx = 3'd3;
      else if (rssi >= -8'sd90) idx = 3'd4;
      else                      idx = 3'd5;
      return idx;
   endfunction

   // Column of the overlap table for a channel distance
   function automatic logic [2:0] overlap_idx(input logic [3:0] cand, input logic [7:0] ch);
      logic [7:0] a;
      logic [7:0] diff;
      logic [2:0] idx;
      a    = {4'd0, cand};
      diff = (a > ch) ? (a - ch) : (ch - a);
      if (diff > 8'd4) idx = 3'd5;
      else             idx = diff[2:0];
      return idx;
   endfunction

   function automatic logic [1:0] level_of(input logic [15:0] s);
      logic [1:0] lvl;
      if (s <= 16'd60)       lvl = LEVEL_EXCELLENT;
      else if (s <= 16'd140) lvl = LEVEL_GOOD;
      else if (s <= 16'd240) lvl = LEVEL_FAIR;
      else                   lvl = LEVEL_POOR;
      return lvl;
   endfunction

endpackage

// ===== rtl/wifi_channel_congestion_recommender.sv =====
// Channel congestion recommender. Each scan entry (req_func = 0) is held in the input
// register and then adds a table-driven congestion term to each of three candidate channels,
// so entries stream at one per cycle while no finish waits in the input register. A finish
// item (req_func = 1) snapshots the scores and the recommendation summary and then presents
// three rows on the rsp channel, one per transfer, the third marked by rsp_last_row; the
// scores and network count clear at the same time. The first row is registered when the
// finish leaves the input register. Entries after a finish keep flowing while its rows
// drain; a second finish waits in the input register until the third row of the previous
// one has been taken. Write the CSRs only while no item is in flight.
module wifi_channel_congestion_recommender (
   input  logic               clock,
   input  logic               reset,
   // Scan input
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_func,
   input  logic signed [7:0]  req_rssi,
   input  logic [7:0]         req_channel,
   // Result rows
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [3:0]         rsp_candidate_channel,
   output logic [15:0]        rsp_congestion_score,
   output logic [1:0]         rsp_congestion_level,
   output logic               rsp_is_best,
   output logic               rsp_is_comparable,
   output logic [15:0]        rsp_second_best_score,
   output logic [15:0]        rsp_score_margin,
   output logic [1:0]         rsp_comparable_count,
   output logic               rsp_unique_best,
   output logic [1:0]         rsp_confidence,
   output logic               rsp_last_row,
   // CSR port
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [4:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);

   // CSR registers
   logic [3:0]  cand_a_ff, cand_b_ff, cand_c_ff;
   logic [15:0] tol_ff, hi_margin_ff;
   logic        csr_wr;
   logic [2:0]  csr_idx;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx    = csr_paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         cand_a_ff    <= wccr_pkg::RST_CAND_A;
         cand_b_ff    <= wccr_pkg::RST_CAND_B;
         cand_c_ff    <= wccr_pkg::RST_CAND_C;
         tol_ff       <= wccr_pkg::RST_TOL;
         hi_margin_ff <= wccr_pkg::RST_HI_MARGIN;
      end else if (csr_wr) begin
         unique case (csr_idx)
            wccr_pkg::REG_CAND_A:    cand_a_ff    <= csr_pwdata[3:0];
            wccr_pkg::REG_CAND_B:    cand_b_ff    <= csr_pwdata[3:0];
            wccr_pkg::REG_CAND_C:    cand_c_ff    <= csr_pwdata[3:0];
            wccr_pkg::REG_TOL:       tol_ff       <= csr_pwdata[15:0];
            wccr_pkg::REG_HI_MARGIN: hi_margin_ff <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         wccr_pkg::REG_CAND_A:    csr_prdata = {28'd0, cand_a_ff};
         wccr_pkg::REG_CAND_B:    csr_prdata = {28'd0, cand_b_ff};
         wccr_pkg::REG_CAND_C:    csr_prdata = {28'd0, cand_c_ff};
         wccr_pkg::REG_TOL:       csr_prdata = {16'd0, tol_ff};
         wccr_pkg::REG_HI_MARGIN: csr_prdata = {16'd0, hi_margin_ff};
         default:                 csr_prdata = 32'd0;
      endcase
   end

   wccr_pkg::cand_vec_type cand;
   assign cand = {cand_c_ff, cand_b_ff, cand_a_ff};

   // Input register
   logic              in_valid_ff, in_valid_in;
   logic              func_ff;
   logic signed [7:0] rssi_ff;
   logic [7:0]        channel_ff;
   logic              req_xfer;
   logic              advance;
   logic              can_load;
   logic              finish_go;

   assign advance   = in_valid_ff && (!func_ff || can_load);
   assign finish_go = advance && func_ff;
   assign req_stall = in_valid_ff && !advance;
   assign req_xfer  = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_xfer)     in_valid_in = 1'b1;
      else if (advance) in_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) in_valid_ff <= 1'b0;
      else       in_valid_ff <= in_valid_in;
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         func_ff    <= req_func;
         rssi_ff    <= req_rssi;
         channel_ff <= req_channel;
      end
   end

   // Score accumulation
   wccr_pkg::score_bank_type bank;

   wccr_accum u_accum (
      .clock    (clock),
      .reset    (reset),
      .entry_en (advance && !func_ff),
      .clear_en (finish_go),
      .rssi     (rssi_ff),
      .channel  (channel_ff),
      .cand     (cand),
      .bank     (bank)
   );

   // Summary and row output
   wccr_emit u_emit (
      .clock                 (clock),
      .reset                 (reset),
      .load_en               (finish_go),
      .bank                  (bank),
      .cand                  (cand),
      .tolerance             (tol_ff),
      .hi_margin             (hi_margin_ff),
      .can_load              (can_load),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_candidate_channel (rsp_candidate_channel),
      .rsp_congestion_score  (rsp_congestion_score),
      .rsp_congestion_level  (rsp_congestion_level),
      .rsp_is_best           (rsp_is_best),
      .rsp_is_comparable     (rsp_is_comparable),
      .rsp_second_best_score (rsp_second_best_score),
      .rsp_score_margin      (rsp_score_margin),
      .rsp_comparable_count  (rsp_comparable_count),
      .rsp_unique_best       (rsp_unique_best),
      .rsp_confidence        (rsp_confidence),
      .rsp_last_row          (rsp_last_row)
   );

`ifndef SYNTH
   // Finish clears the bank and starts a burst at the first row
   a_finish_clears: assert property (@(posedge clock) disable iff (reset)
      finish_go |=> (bank.score == '0) && (bank.count == '0) && rsp_valid && !rsp_last_row)
      else $error("finish did not clear scores or start a row burst");

   // Network counter never passes its limit
   a_count_limit: assert property (@(posedge clock) disable iff (reset)
      bank.count <= wccr_pkg::CNT_W'(wccr_pkg::MAX_NETWORKS))
      else $error("network count above limit");

   // The best row is always comparable
   a_best_comparable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_best |-> rsp_is_comparable && (rsp_comparable_count != 2'd0))
      else $error("best row not comparable");

   // High confidence only with a single comparable candidate
   a_high_unique: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_confidence == wccr_pkg::CONF_HIGH) |-> rsp_unique_best)
      else $error("high confidence without a unique best");
`endif

endmodule

// ===== rtl/wccr_accum.sv =====
module wccr_accum (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  entry_en,
   input  logic                  clear_en,
   input  logic signed [7:0]     rssi,
   input  logic [7:0]            channel,
   input  wccr_pkg::cand_vec_type cand,
   output wccr_pkg::score_bank_type bank
);

   logic [15:0] score_ff [wccr_pkg::NUM_CAND];
   logic [15:0] score_in [wccr_pkg::NUM_CAND];
   logic [wccr_pkg::CNT_W-1:0] count_ff;
   logic [wccr_pkg::CNT_W-1:0] count_in;

   logic       full;
   logic       ch_ok;
   logic [2:0] imp;
   logic [6:0] term [wccr_pkg::NUM_CAND];
   logic [16:0] sum [wccr_pkg::NUM_CAND];

   // Per-candidate term from the table, saturating add
   assign full  = count_ff >= wccr_pkg::CNT_W'(wccr_pkg::MAX_NETWORKS);
   assign ch_ok = (channel != 8'd0) && (channel <= 8'(wccr_pkg::MAX_CHANNEL));
   assign imp   = wccr_pkg::impact_idx(rssi);

   always_comb begin
      for (int i = 0; i < wccr_pkg::NUM_CAND; i++) begin
         term[i] = wccr_pkg::TERM_TABLE[imp][wccr_pkg::overlap_idx(cand[i], channel)];
         sum[i]  = {1'b0, score_ff[i]} + 17'(term[i]);
      end
   end

   // Next state: clear on finish, accumulate on a counted entry
   always_comb begin
      count_in = count_ff;
      for (int i = 0; i < wccr_pkg::NUM_CAND; i++) begin
         score_in[i] = score_ff[i];
      end
      if (clear_en) begin
         count_in = '0;
         for (int i = 0; i < wccr_pkg::NUM_CAND; i++) begin
            score_in[i] = '0;
         end
      end else if (entry_en && !full) begin
         count_in = count_ff + 1'b1;
         if (ch_ok) begin
            for (int i = 0; i < wccr_pkg::NUM_CAND; i++) begin
               score_in[i] = sum[i][16] ? wccr_pkg::SCORE_MAX : sum[i][15:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         for (int i = 0; i < wccr_pkg::NUM_CAND; i++) begin
            score_ff[i] <= '0;
         end
      end else begin
         count_ff <= count_in;
         for (int i = 0; i < wccr_pkg::NUM_CAND; i++) begin
            score_ff[i] <= score_in[i];
         end
      end
   end

   always_comb begin
      for (int i = 0; i < wccr_pkg::NUM_CAND; i++) begin
         bank.score[i] = score_ff[i];
      end
      bank.count   = count_ff;
      bank.counted = count_ff != '0;
   end

endmodule

// ===== rtl/wccr_emit.sv =====
module wccr_emit (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     load_en,
   input  wccr_pkg::score_bank_type bank,
   input  wccr_pkg::cand_vec_type   cand,
   input  logic [15:0]              tolerance,
   input  logic [15:0]              hi_margin,
   output logic                     can_load,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [3:0]               rsp_candidate_channel,
   output logic [15:0]              rsp_congestion_score,
   output logic [1:0]               rsp_congestion_level,
   output logic                     rsp_is_best,
   output logic                     rsp_is_comparable,
   output logic [15:0]              rsp_second_best_score,
   output logic [15:0]              rsp_score_margin,
   output logic [1:0]               rsp_comparable_count,
   output logic                     rsp_unique_best,
   output logic [1:0]               rsp_confidence,
   output logic                     rsp_last_row
);

   // Summary of the finished scan
   logic [15:0] best;
   logic [15:0] second;
   logic [wccr_pkg::NUM_CAND-1:0] best_oh;
   logic [wccr_pkg::NUM_CAND-1:0] comp;
   logic        have_best;
   logic [16:0] limit;
   logic [1:0]  count;
   logic [15:0] margin;
   logic [1:0]  conf;

   always_comb begin
      best    = wccr_pkg::SCORE_MAX;
      second  = wccr_pkg::SCORE_MAX;
      best_oh = '0;
      for (int i = 0; i < wccr_pkg::NUM_CAND; i++) begin
         if (bank.score[i] < best) begin
            second     = best;
            best       = bank.score[i];
            best_oh    = '0;
            best_oh[i] = 1'b1;
         end else if (bank.score[i] < second) begin
            second = bank.score[i];
         end
      end
   end

   assign have_best = |best_oh;
   assign limit     = {1'b0, best} + {1'b0, tolerance};

   always_comb begin
      for (int i = 0; i < wccr_pkg::NUM_CAND; i++) begin
         comp[i] = have_best && ({1'b0, bank.score[i]} <= limit);
      end
   end

   assign count  = 2'(comp[0]) + 2'(comp[1]) + 2'(comp[2]);
   assign margin = have_best ? (second - best) : 16'd0;

   always_comb begin
      if (!have_best || !bank.counted) conf = wccr_pkg::CONF_UNKNOWN;
      else if (count > 2'd1)           conf = wccr_pkg::CONF_LOW;
      else if (margin >= hi_margin)    conf = wccr_pkg::CONF_HIGH;
      else                             conf = wccr_pkg::CONF_MEDIUM;
   end

   // Snapshot of the three rows, read out one row per transfer
   logic                          valid_ff, valid_in;
   logic [1:0]                    row_ff, row_in;
   wccr_pkg::cand_vec_type        chan_ff;
   logic [wccr_pkg::NUM_CAND-1:0][15:0] score_ff;
   logic [wccr_pkg::NUM_CAND-1:0] best_ff;
   logic [wccr_pkg::NUM_CAND-1:0] comp_ff;
   logic [15:0]                   second_ff;
   logic [15:0]                   margin_ff;
   logic [1:0]                    count_ff;
   logic [1:0]                    conf_ff;
   logic                          rsp_xfer;

   assign rsp_xfer = valid_ff && !rsp_stall;
   assign can_load = !valid_ff || (rsp_xfer && (row_ff == wccr_pkg::LAST_ROW));

   always_comb begin
      valid_in = valid_ff;
      row_in   = row_ff;
      if (load_en) begin
         valid_in = 1'b1;
         row_in   = '0;
      end else if (rsp_xfer) begin
         if (row_ff == wccr_pkg::LAST_ROW) valid_in = 1'b0;
         else                              row_in   = row_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         row_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         row_ff   <= row_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_en) begin
         chan_ff   <= cand;
         score_ff  <= bank.score;
         best_ff   <= best_oh;
         comp_ff   <= comp;
         second_ff <= second;
         margin_ff <= margin;
         count_ff  <= count;
         conf_ff   <= conf;
      end
   end

   // Row select
   assign rsp_valid             = valid_ff;
   assign rsp_candidate_channel = chan_ff[row_ff];
   assign rsp_congestion_score  = score_ff[row_ff];
   assign rsp_congestion_level  = wccr_pkg::level_of(score_ff[row_ff]);
   assign rsp_is_best           = best_ff[row_ff];
   assign rsp_is_comparable     = comp_ff[row_ff];
   assign rsp_second_best_score = second_ff;
   assign rsp_score_margin      = margin_ff;
   assign rsp_comparable_count  = count_ff;
   assign rsp_unique_best       = count_ff == 2'd1;
   assign rsp_confidence        = conf_ff;
   assign rsp_last_row          = row_ff == wccr_pkg::LAST_ROW;

endmodule
